@@ rtl/core/aip_pkg.sv @@
// Shared types, character codes and helper functions for the ASCII integer parser.
// Used by the channel interfaces, the parser core and the top level.
package aip_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned DIGIT_W  = 7;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CH_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CH_W-1:0] CH_UC_X  = 8'h58;

  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

  // Marks a character that is neither digit nor letter; above every base.
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'h7F;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_DIGITS = 3'd2,
    PH_DONE   = 3'd3
  } phase_e;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic               first;
    logic [RADIX_W-1:0] radix;
  } word_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic                negative;
    logic [OFFSET_W-1:0] end_offset;
  } result_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_NONE;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if ((c >= CH_LC_A) && (c <= CH_LC_Z)) begin
      d = DIGIT_W'(c - CH_LC_A) + DIGIT_W'(10);
    end else if ((c >= CH_UC_A) && (c <= CH_UC_Z)) begin
      d = DIGIT_W'(c - CH_UC_A) + DIGIT_W'(10);
    end
    return d;
  endfunction

endpackage

@@ rtl/core/aip_if.sv @@
// Valid/ready channel interfaces for the character input and the result output.
// Depends on aip_pkg for field widths.
interface aip_in_if;
  import aip_pkg::*;
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    ch;
  logic               first;
  logic [RADIX_W-1:0] radix;
  modport source (output valid, output ch, output first, output radix, input ready);
  modport sink   (input valid, input ch, input first, input radix, output ready);
endinterface

interface aip_out_if;
  import aip_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic                negative;
  logic [OFFSET_W-1:0] end_offset;
  modport source (output valid, output value, output negative, output end_offset, input ready);
  modport sink   (input valid, input value, input negative, input end_offset, output ready);
endinterface

@@ rtl/core/aip_in_stage.sv @@
// Input register stage: captures one character word per handshake.
// Depends on aip_pkg for the word type.
module aip_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  aip_pkg::word_t word_i,
  output logic           ready_o,
  input  logic           take_i,
  output logic           valid_o,
  output aip_pkg::word_t word_o
);
  import aip_pkg::*;

  logic  valid_q;
  word_t word_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

endmodule

@@ rtl/core/aip_core.sv @@
// Parse state and single-step character logic: one word per enabled cycle.
// Depends on aip_pkg for types, character codes and digit decode.
module aip_core #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  aip_pkg::word_t   word_i,
  output logic             emit_o,
  output aip_pkg::result_t result_o
);
  import aip_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_LEN);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_LEN - 1);

  phase_e             phase_q, phase_d, ph;
  logic [VALUE_W-1:0] acc_q, acc_d, acc;
  logic               minus_q, minus_d, mn;
  logic [RADIX_W-1:0] base_q, base_d, base, dig_base;
  logic [PosW-1:0]    pos_q, pos_d, pos;
  logic               zero_q, zero_d, zp;
  logic [CH_W-1:0]    c;
  logic [DIGIT_W-1:0] dval;
  logic               adv, to_sig, to_dig, take_digit, is_x;
  logic [VALUE_W+RADIX_W-1:0] prod;
  logic [PosW+OFFSET_W-1:0]   pos_ext;

  always_comb begin
    ph  = phase_q;
    acc = acc_q;
    mn  = minus_q;
    base = base_q;
    pos = pos_q;
    zp  = zero_q;
    // A first mark restarts the parse with this word.
    if (word_i.first) begin
      ph   = PH_LEAD;
      acc  = '0;
      mn   = 1'b0;
      base = word_i.radix;
      pos  = '0;
      zp   = 1'b0;
    end
    c    = word_i.ch;
    dval = digit_of(c);
    is_x = (c == CH_LC_X) || (c == CH_UC_X);

    phase_d  = ph;
    acc_d    = acc;
    minus_d  = mn;
    zero_d   = zp;
    dig_base = base;
    adv      = 1'b0;
    emit_o   = 1'b0;
    to_sig   = 1'b0;
    to_dig   = 1'b0;
    take_digit = 1'b0;
    prod     = '0;

    case (ph)
      PH_LEAD: begin
        if (is_space(c)) begin
          adv = 1'b1;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          minus_d = (c == CH_MINUS);
          adv     = 1'b1;
          phase_d = PH_SIGNED;
        end else begin
          to_sig = 1'b1;
        end
      end
      PH_SIGNED: to_sig = 1'b1;
      PH_DIGITS: to_dig = 1'b1;
      PH_DONE:   ;
      default:   ;
    endcase

    if (to_sig) begin
      phase_d = PH_DIGITS;
      if (((base == BASE_AUTO) || (base == BASE_HEX)) && (c == CH_ZERO)) begin
        zero_d = 1'b1;
        adv    = 1'b1;
      end else begin
        if (base == BASE_AUTO) begin
          dig_base = BASE_DEC;
        end
        to_dig = 1'b1;
      end
    end

    if (to_dig) begin
      take_digit = 1'b1;
      if (zp) begin
        zero_d = 1'b0;
        if (is_x) begin
          dig_base   = BASE_HEX;
          adv        = 1'b1;
          take_digit = 1'b0;
        end else if (base == BASE_AUTO) begin
          dig_base = BASE_OCT;
        end
      end
    end

    if (take_digit) begin
      prod = {RADIX_W'(0), acc} * {VALUE_W'(0), dig_base};
      if (dval < {1'b0, dig_base}) begin
        acc_d = prod[VALUE_W-1:0] + VALUE_W'(dval);
        adv   = 1'b1;
      end else begin
        emit_o  = 1'b1;
        phase_d = PH_DONE;
      end
    end

    base_d = dig_base;
    pos_d  = (adv && (pos != PosMax)) ? pos + PosW'(1) : pos;

    pos_ext             = {OFFSET_W'(0), pos};
    result_o.value      = mn ? (VALUE_W'(0) - acc) : acc;
    result_o.negative   = mn;
    result_o.end_offset = pos_ext[OFFSET_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      acc_q   <= '0;
      minus_q <= 1'b0;
      base_q  <= '0;
      pos_q   <= '0;
      zero_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      base_q  <= base_d;
      pos_q   <= pos_d;
      zero_q  <= zero_d;
    end
  end

endmodule

@@ rtl/core/ascii_integer_parser.sv @@
// ASCII integer parser, strtoull style, one character word per cycle while results are taken.
// A terminating character yields its result through the input register, then the
// parse step into the result register.
// Throughput: one word per cycle while the result side takes results; the
// parse state is updated by a single 64x6 multiply-add per step.
// Reset: asynchronous, active low; the parser waits for a first-marked word.
module ascii_integer_parser #(
  parameter int unsigned MAX_LEN = 1024
) (
  input logic          clk_i,
  input logic          rst_ni,
  aip_in_if.sink       in_i,
  aip_out_if.source    out_o
);
  import aip_pkg::*;

  word_t   in_word;
  word_t   cur_word;
  logic    cur_valid;
  logic    step;        // held word is parsed this cycle
  logic    room;        // result register can take a new result
  logic    emit;
  result_t core_res;
  result_t res_q;
  logic    out_valid_q;

  assign in_word.ch    = in_i.ch;
  assign in_word.first = in_i.first;
  assign in_word.radix = in_i.radix;

  // Advance the held word whenever the result register is free or draining.
  assign room = !out_valid_q || out_o.ready;
  assign step = cur_valid && room;

  aip_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .word_i  (in_word),
    .ready_o (in_i.ready),
    .take_i  (step),
    .valid_o (cur_valid),
    .word_o  (cur_word)
  );

  aip_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (cur_word),
    .emit_o   (emit),
    .result_o (core_res)
  );

  // Result register: load on a terminating character, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_q <= core_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.value      = res_q.value;
  assign out_o.negative   = res_q.negative;
  assign out_o.end_offset = res_q.end_offset;

  // A held word is never dropped while the result side stalls.
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid && !room |=> cur_valid && $stable(cur_word))
    else $error("held word lost during stall");

  // An empty result register always lets a word in.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // A terminating step shows its result in the next cycle.
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit |=> out_valid_q && (out_o.negative == $past(core_res.negative)))
    else $error("result not loaded after terminating character");

endmodule
